>>> rtl/core/bal_pkg.sv
// ----------------------------------------------------------------------------
// bal_pkg: shared types and constants of the bounded array list
// Request and status codes, store sizes, and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bal_pkg;

    localparam int ADDR_W = 6;   // address bits of the entry store
    localparam int CNT_W  = 7;   // count and position width
    localparam int WORD_W = 32;
    localparam int MODE_W = 3;
    localparam int STAT_W = 2;

    localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(64);

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 3'd0,
        MODE_INSERT = 3'd1,
        MODE_REMOVE = 3'd2,
        MODE_READ   = 3'd3,
        MODE_WRITE  = 3'd4,
        MODE_SEARCH = 3'd5,
        MODE_CLEAR  = 3'd6
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    // Where a word write from the request lands.
    typedef enum logic {
        WA_COUNT = 1'b0,
        WA_POS   = 1'b1
    } t_waddr;

    typedef struct packed {
        logic    load;       // capture the request
        logic    st_wr;      // latch the status code below
        t_status st;
        logic    ptr_cnt;    // pointer <= count
        logic    ptr_pos;    // pointer <= position
        logic    ptr_zero;   // pointer <= 0
        logic    step_up;    // one move of the insert shift
        logic    step_dn;    // one move of the remove shift
        logic    step_scan;  // one compare of the search
        logic    cap_rd;     // take the read data as the result word
        logic    wr_word;    // write the request word
        t_waddr  wa_sel;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    cnt_clr;
        logic    publish;    // move the result into the output register
    } t_cmd;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              full;
        logic              pos_gt_cnt;
        logic              pos_ge_cnt;
        logic              up_more;
        logic              dn_more;
        logic              scan_more;
        logic              pend;      // shifted word still to be written
        logic              cmp_pend;  // read data still to be compared
        logic              out_free;
    } t_sts;

endpackage

`default_nettype wire

>>> rtl/core/bal_ctrl.sv
// ----------------------------------------------------------------------------
// bal_ctrl: request sequencer of the bounded array list
// Decodes each request, runs the shift and search walks over the store and
// hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bal_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire bal_pkg::t_sts i_sts,
    output bal_pkg::t_cmd      o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DECODE   = 7'b0000010,
        S_SHIFT_UP = 7'b0000100,
        S_SHIFT_DN = 7'b0001000,
        S_SCAN     = 7'b0010000,
        S_RD_WAIT  = 7'b0100000,
        S_DONE     = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.st   = bal_pkg::ST_OK;
        o_cmd.wa_sel = bal_pkg::WA_COUNT;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.st_wr = 1'b1;
                n_state     = S_DONE;
                unique case (bal_pkg::t_mode'(i_sts.mode))
                    bal_pkg::MODE_APPEND: begin
                        if (i_sts.full) begin
                            o_cmd.st = bal_pkg::ST_FULL;
                        end else begin
                            o_cmd.wr_word = 1'b1;
                            o_cmd.wa_sel  = bal_pkg::WA_COUNT;
                            o_cmd.cnt_inc = 1'b1;
                        end
                    end
                    bal_pkg::MODE_INSERT: begin
                        // The index check comes before the full check.
                        if (i_sts.pos_gt_cnt) begin
                            o_cmd.st = bal_pkg::ST_RANGE;
                        end else if (i_sts.full) begin
                            o_cmd.st = bal_pkg::ST_FULL;
                        end else begin
                            o_cmd.ptr_cnt = 1'b1;
                            n_state       = S_SHIFT_UP;
                        end
                    end
                    bal_pkg::MODE_REMOVE: begin
                        if (i_sts.pos_ge_cnt) begin
                            o_cmd.st = bal_pkg::ST_RANGE;
                        end else begin
                            o_cmd.ptr_pos = 1'b1;
                            n_state       = S_SHIFT_DN;
                        end
                    end
                    bal_pkg::MODE_READ: begin
                        if (i_sts.pos_ge_cnt) begin
                            o_cmd.st = bal_pkg::ST_RANGE;
                        end else begin
                            // The store is already being read at the position.
                            n_state = S_RD_WAIT;
                        end
                    end
                    bal_pkg::MODE_WRITE: begin
                        if (i_sts.pos_ge_cnt) begin
                            o_cmd.st = bal_pkg::ST_RANGE;
                        end else begin
                            o_cmd.wr_word = 1'b1;
                            o_cmd.wa_sel  = bal_pkg::WA_POS;
                        end
                    end
                    bal_pkg::MODE_SEARCH: begin
                        o_cmd.ptr_zero = 1'b1;
                        n_state        = S_SCAN;
                    end
                    bal_pkg::MODE_CLEAR: begin
                        o_cmd.cnt_clr = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            S_SHIFT_UP: begin
                // The last shifted word drains before the new word goes in.
                if (i_sts.up_more) begin
                    o_cmd.step_up = 1'b1;
                end else if (!i_sts.pend) begin
                    o_cmd.wr_word = 1'b1;
                    o_cmd.wa_sel  = bal_pkg::WA_POS;
                    o_cmd.cnt_inc = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_SHIFT_DN: begin
                if (i_sts.dn_more) begin
                    o_cmd.step_dn = 1'b1;
                end else if (!i_sts.pend) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_more) begin
                    o_cmd.step_scan = 1'b1;
                end else if (!i_sts.cmp_pend) begin
                    n_state = S_DONE;
                end
            end
            S_RD_WAIT: begin
                o_cmd.cap_rd = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/bal_dpath.sv
// ----------------------------------------------------------------------------
// bal_dpath: storage and datapath of the bounded array list
// Entry store with one write and one registered read port, the count, the
// walk pointer, the request and result registers and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bal_dpath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire bal_pkg::t_cmd                 i_cmd,
    output bal_pkg::t_sts                      o_sts,
    input  wire logic [bal_pkg::MODE_W-1:0]    i_mode,
    input  wire logic [bal_pkg::CNT_W-1:0]     i_position,
    input  wire logic signed [bal_pkg::WORD_W-1:0] i_word,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic signed [bal_pkg::WORD_W-1:0]  o_read_word,
    output logic                               o_found,
    output logic [bal_pkg::CNT_W-1:0]          o_count,
    output logic [bal_pkg::STAT_W-1:0]         o_status
);

    logic [bal_pkg::WORD_W-1:0] r_mem [0:(1 << bal_pkg::ADDR_W)-1];

    logic [bal_pkg::MODE_W-1:0] r_mode;
    logic [bal_pkg::CNT_W-1:0]  r_pos;
    logic [bal_pkg::WORD_W-1:0] r_word;
    logic [bal_pkg::CNT_W-1:0]  r_count, n_count;
    logic [bal_pkg::CNT_W-1:0]  r_ptr, n_ptr;
    logic [bal_pkg::ADDR_W-1:0] r_wa;
    logic                       r_pend;
    logic                       r_cmp_pend;
    logic [bal_pkg::WORD_W-1:0] r_rdata;
    logic                       r_found;
    logic [bal_pkg::WORD_W-1:0] r_rword;
    bal_pkg::t_status           r_st;

    logic                       r_out_valid;
    logic [bal_pkg::WORD_W-1:0] r_out_rword;
    logic                       r_out_found;
    logic [bal_pkg::CNT_W-1:0]  r_out_count;
    logic [bal_pkg::STAT_W-1:0] r_out_status;

    logic [bal_pkg::CNT_W-1:0]  ptr_m1, ptr_p1;
    logic [bal_pkg::ADDR_W-1:0] rd_addr;
    logic                       wr_en;
    logic [bal_pkg::ADDR_W-1:0] wr_addr;
    logic [bal_pkg::WORD_W-1:0] wr_data;

    assign ptr_m1 = r_ptr - bal_pkg::CNT_W'(1);
    assign ptr_p1 = r_ptr + bal_pkg::CNT_W'(1);

    always_comb begin
        priority if (i_cmd.step_up) begin
            rd_addr = ptr_m1[bal_pkg::ADDR_W-1:0];
        end else if (i_cmd.step_dn) begin
            rd_addr = ptr_p1[bal_pkg::ADDR_W-1:0];
        end else if (i_cmd.step_scan) begin
            rd_addr = r_ptr[bal_pkg::ADDR_W-1:0];
        end else begin
            rd_addr = r_pos[bal_pkg::ADDR_W-1:0];
        end
    end

    // A word read in a shift step is written in the next cycle, one place over.
    always_comb begin
        wr_en   = r_pend | i_cmd.wr_word;
        wr_addr = r_wa;
        wr_data = r_rdata;
        if (!r_pend) begin
            wr_data = r_word;
            wr_addr = (i_cmd.wa_sel == bal_pkg::WA_POS) ? r_pos[bal_pkg::ADDR_W-1:0]
                                                        : r_count[bal_pkg::ADDR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_comb begin
        n_count = r_count;
        priority if (i_cmd.cnt_clr) begin
            n_count = '0;
        end else if (i_cmd.cnt_inc) begin
            n_count = r_count + bal_pkg::CNT_W'(1);
        end else if (i_cmd.cnt_dec) begin
            n_count = r_count - bal_pkg::CNT_W'(1);
        end
    end

    always_comb begin
        n_ptr = r_ptr;
        priority if (i_cmd.ptr_cnt) begin
            n_ptr = r_count;
        end else if (i_cmd.ptr_pos) begin
            n_ptr = r_pos;
        end else if (i_cmd.ptr_zero) begin
            n_ptr = '0;
        end else if (i_cmd.step_up) begin
            n_ptr = ptr_m1;
        end else if (i_cmd.step_dn || i_cmd.step_scan) begin
            n_ptr = ptr_p1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_cmp_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_pend     <= i_cmd.step_up | i_cmd.step_dn;
            r_cmp_pend <= i_cmd.step_scan;
            if (i_cmd.publish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        if (i_cmd.step_up || i_cmd.step_dn) begin
            r_wa <= r_ptr[bal_pkg::ADDR_W-1:0];
        end
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_pos   <= i_position;
            r_word  <= i_word;
            r_found <= 1'b0;
            r_rword <= '0;
        end else begin
            if (r_cmp_pend && (r_rdata == r_word)) begin
                r_found <= 1'b1;
            end
            if (i_cmd.cap_rd) begin
                r_rword <= r_rdata;
            end
        end
        if (i_cmd.st_wr) begin
            r_st <= i_cmd.st;
        end
        if (i_cmd.publish) begin
            r_out_rword  <= r_rword;
            r_out_found  <= r_found;
            r_out_count  <= r_count;
            r_out_status <= r_st;
        end
    end

    always_comb begin
        o_sts.mode       = r_mode;
        o_sts.full       = (r_count == bal_pkg::CAPACITY);
        o_sts.pos_gt_cnt = (r_pos > r_count);
        o_sts.pos_ge_cnt = (r_pos >= r_count);
        o_sts.up_more    = (r_ptr != r_pos);
        o_sts.dn_more    = (ptr_p1 < r_count);
        o_sts.scan_more  = (r_ptr < r_count);
        o_sts.pend       = r_pend;
        o_sts.cmp_pend   = r_cmp_pend;
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_read_word = r_out_rword;
    assign o_found     = r_out_found;
    assign o_count     = r_out_count;
    assign o_status    = r_out_status;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= bal_pkg::CAPACITY)
        else $error("entry count beyond capacity");

    a_wr_conflict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pend && i_cmd.wr_word))
        else $error("word write collides with a pending shift write");

    a_count_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.cnt_inc && !i_cmd.cnt_clr) |=>
            (r_count == $past(r_count) + bal_pkg::CNT_W'(1)))
        else $error("count did not step up");

    a_publish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.publish |-> (!r_out_valid || i_out_ready))
        else $error("result overwrote an untaken word");
`endif

endmodule

`default_nettype wire

>>> rtl/core/bounded_array_list.sv
// ----------------------------------------------------------------------------
// bounded_array_list: fixed-capacity ordered list of signed 32-bit words
// Top level: request sequencer plus store datapath.
// ----------------------------------------------------------------------------
// One request is taken at a time and gives one result word carrying the
// count after the request and a status. Append, write, clear and refused
// requests are settled in the decode state, and a read first captures the
// data read from the store. Insert, remove and search walk the store,
// which moves or compares one entry per cycle. The next request is
// taken once the current result is in the output register, even if that
// word is still untaken.
`default_nettype none

module bounded_array_list (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [bal_pkg::MODE_W-1:0]        i_mode,
    input  wire logic [bal_pkg::CNT_W-1:0]         i_position,
    input  wire logic signed [bal_pkg::WORD_W-1:0] i_word,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic signed [bal_pkg::WORD_W-1:0]      o_read_word,
    output logic                                   o_found,
    output logic [bal_pkg::CNT_W-1:0]              o_count,
    output logic [bal_pkg::STAT_W-1:0]             o_status
);

    bal_pkg::t_cmd cmd;
    bal_pkg::t_sts sts;

    bal_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bal_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_mode      (i_mode),
        .i_position  (i_position),
        .i_word      (i_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_read_word (o_read_word),
        .o_found     (o_found),
        .o_count     (o_count),
        .o_status    (o_status)
    );

endmodule

`default_nettype wire
